### hdl/lfu_pkg.sv
package lfu_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int USE_W   = 32;
    localparam int CAP_W   = 5;
    localparam int CAP_RESET = 16;

    localparam logic [VAL_W-1:0] MISS_DATA = '1;
    localparam logic [USE_W-1:0] USE_MAX   = '1;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // one stored entry: key, value, use count and recency rank
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [USE_W-1:0] use_count;
        logic [IDX_W-1:0] rank;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

### hdl/lfu_ram.sv
// Single port synchronous RAM, registered read.
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH_P = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH_P];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### hdl/lfu_cache_lru_tiebreak.sv
// Channel  | Valid/Ready        | Payload
// ---------+--------------------+-------------------------
// request  | in_valid/in_ready  | operation, key, value
// result   | out_valid/out_ready| hit, data
// config   | cfg_valid/cfg_ready| cfg_data (capacity)
//
// Each request scans the entry RAM for the key, a free slot and the victim,
// decides, runs a read-modify-write pass over every entry (a read state and a
// write state per entry) that fixes ranks and writes the target, and then posts
// the result. A get miss or a dropped put skips the rewrite pass.
// Valid bits and occupancy live in flops and clear at reset; RAM is not cleared.
// A new request is taken once the previous result has left the output register.
module lfu_cache_lru_tiebreak (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] key,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic [31:0] data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    localparam int IW = lfu_pkg::IDX_W;
    localparam int DW = lfu_pkg::DEPTH;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_UPD_RD, S_UPD, S_DONE
    } state_t;

    state_t state_reg;
    logic [lfu_pkg::CAP_W-1:0] cap_reg;
    logic [DW-1:0]             valid_reg;
    logic [lfu_pkg::CNT_W-1:0] occ_reg;

    // latched request
    logic                      op_reg;
    logic [31:0]               key_reg;
    logic [31:0]               val_reg;

    // scan pass bookkeeping
    logic [IW:0]               ptr_reg;     // address counter, one extra bit
    logic [IW-1:0]             rd_idx_reg;  // address of data on rdata
    logic                      rd_ok_reg;
    logic                      found_reg;
    logic [IW-1:0]             fidx_reg;
    logic [IW-1:0]             frank_reg;
    logic [31:0]               fval_reg;
    logic [31:0]               fuse_reg;
    logic                      free_ok_reg;
    logic [IW-1:0]             free_reg;
    logic                      vic_ok_reg;
    logic [IW-1:0]             vic_reg;
    logic [31:0]               vuse_reg;
    logic [IW-1:0]             vrank_reg;

    // update plan
    typedef enum logic [1:0] { A_NONE, A_BUMP, A_INS, A_EVINS } act_t;
    act_t                      act_reg;
    logic [IW-1:0]             tgt_reg;

    logic                      out_valid_reg;
    logic                      hit_reg;
    logic [31:0]               data_reg;

    // RAM port
    logic                      ram_we;
    logic [IW-1:0]             ram_addr;
    lfu_pkg::entry_t           ram_wdata, ram_rdata;

    lfu_ram #(
        .WIDTH  (lfu_pkg::ENTRY_W),
        .DEPTH_P(lfu_pkg::DEPTH),
        .ADDR_W (IW)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign data      = data_reg;

    // effective capacity, saturated at DEPTH
    logic [lfu_pkg::CAP_W:0] cap_eff;
    always_comb
    begin
        if ({1'b0, cap_reg} > (lfu_pkg::CAP_W+1)'(DW))
            cap_eff = (lfu_pkg::CAP_W+1)'(DW);
        else
            cap_eff = {1'b0, cap_reg};
    end

    // scan-pass entry compare
    logic cur_v;
    logic key_m;
    logic vic_better;
    always_comb
    begin
        cur_v = valid_reg[rd_idx_reg];
        key_m = rd_ok_reg && cur_v && (ram_rdata.key == key_reg);
        vic_better = !vic_ok_reg || (ram_rdata.use_count < vuse_reg) ||
                     ((ram_rdata.use_count == vuse_reg) && (ram_rdata.rank > vrank_reg));
    end

    // update-pass rewrite of one entry
    logic            idx_v;
    lfu_pkg::entry_t upd;
    always_comb
    begin
        upd   = ram_rdata;
        idx_v = valid_reg[rd_idx_reg];
        case (act_reg)
            A_BUMP:
            begin
                if (rd_idx_reg == tgt_reg)
                begin
                    upd.rank = '0;
                    if (op_reg == lfu_pkg::OP_PUT)
                        upd.value = val_reg;
                    if (ram_rdata.use_count != lfu_pkg::USE_MAX)
                        upd.use_count = ram_rdata.use_count + 32'd1;
                end
                else if (ram_rdata.rank < frank_reg)
                begin
                    upd.rank = ram_rdata.rank + IW'(1);
                end
            end
            A_INS:
            begin
                if (rd_idx_reg == tgt_reg)
                    upd = '{key: key_reg, value: val_reg, use_count: 32'd1, rank: '0};
                else
                    upd.rank = ram_rdata.rank + IW'(1);
            end
            A_EVINS:
            begin
                if (rd_idx_reg == tgt_reg)
                    upd = '{key: key_reg, value: val_reg, use_count: 32'd1, rank: '0};
                else if (ram_rdata.rank < vrank_reg)
                    upd.rank = ram_rdata.rank + IW'(1);
            end
            default:
            begin
                upd = ram_rdata;
            end
        endcase
    end

    // RAM address/write control
    always_comb
    begin
        ram_addr  = ptr_reg[IW-1:0];
        ram_we    = 1'b0;
        ram_wdata = upd;
        if (state_reg == S_UPD)
        begin
            ram_addr = rd_idx_reg;
            ram_we   = idx_v || (rd_idx_reg == tgt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= lfu_pkg::CAP_W'(lfu_pkg::CAP_RESET);
            valid_reg     <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            ptr_reg       <= '0;
            rd_ok_reg     <= 1'b0;
            act_reg       <= A_NONE;
        end
        else
        begin
            if (cfg_valid)
                cap_reg <= cfg_data;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        op_reg      <= operation;
                        key_reg     <= key;
                        val_reg     <= value;
                        ptr_reg     <= '0;
                        rd_ok_reg   <= 1'b0;
                        found_reg   <= 1'b0;
                        free_ok_reg <= 1'b0;
                        vic_ok_reg  <= 1'b0;
                        state_reg   <= S_SCAN;
                    end
                end
                // read every entry; data arrives in the cycle after its address
                S_SCAN:
                begin
                    rd_idx_reg <= ptr_reg[IW-1:0];
                    rd_ok_reg  <= !ptr_reg[IW];
                    if (!ptr_reg[IW])
                        ptr_reg <= ptr_reg + (IW+1)'(1);
                    if (rd_ok_reg)
                    begin
                        if (key_m && !found_reg)
                        begin
                            found_reg <= 1'b1;
                            fidx_reg  <= rd_idx_reg;
                            frank_reg <= ram_rdata.rank;
                            fval_reg  <= ram_rdata.value;
                        end
                        if (!cur_v && !free_ok_reg)
                        begin
                            free_ok_reg <= 1'b1;
                            free_reg    <= rd_idx_reg;
                        end
                        if (cur_v && vic_better)
                        begin
                            vic_ok_reg <= 1'b1;
                            vic_reg    <= rd_idx_reg;
                            vuse_reg   <= ram_rdata.use_count;
                            vrank_reg  <= ram_rdata.rank;
                        end
                    end
                    if (ptr_reg[IW] && !rd_ok_reg)
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (found_reg && (op_reg == lfu_pkg::OP_GET || cap_eff != '0))
                    begin
                        act_reg <= A_BUMP;
                        tgt_reg <= fidx_reg;
                    end
                    else if (!found_reg && op_reg == lfu_pkg::OP_PUT && cap_eff != '0 &&
                             {1'b0, occ_reg} >= cap_eff && vic_ok_reg)
                    begin
                        act_reg <= A_EVINS;
                        tgt_reg <= vic_reg;
                    end
                    else if (!found_reg && op_reg == lfu_pkg::OP_PUT && cap_eff != '0 &&
                             free_ok_reg)
                    begin
                        act_reg <= A_INS;
                        tgt_reg <= free_reg;
                        occ_reg <= occ_reg + lfu_pkg::CNT_W'(1);
                        valid_reg[free_reg] <= 1'b1;
                    end
                    else
                    begin
                        act_reg <= A_NONE;
                    end
                    hit_reg  <= found_reg;
                    data_reg <= (found_reg && op_reg == lfu_pkg::OP_GET) ?
                                fval_reg : lfu_pkg::MISS_DATA;
                    ptr_reg  <= '0;
                    state_reg <= S_UPD_RD;
                end
                // read entry at ptr
                S_UPD_RD:
                begin
                    if (act_reg == A_NONE)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        rd_idx_reg <= ptr_reg[IW-1:0];
                        ptr_reg    <= ptr_reg + (IW+1)'(1);
                        state_reg  <= S_UPD;
                    end
                end
                // write back modified entry, then read the next
                S_UPD:
                begin
                    if (ptr_reg[IW])
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_UPD_RD;
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/lfu_checker.sv
module lfu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        hit,
    input logic [31:0] data
);

    // result holds while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data) && $stable(hit))
        else $error("result changed while stalled");

    // no new request while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while result pending");

    // a request cannot produce a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result too early");

    // a miss always carries all ones
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> data == 32'hFFFF_FFFF)
        else $error("miss data not all ones");

endmodule

bind lfu_cache_lru_tiebreak lfu_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit), .data(data)
);

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 2 * lfu_pkg::DEPTH + 10;

    // one cache request as sent to the block
    typedef struct {
        logic                      op;
        logic [lfu_pkg::KEY_W-1:0] k;
        logic [lfu_pkg::VAL_W-1:0] v;
    } cache_req_t;

    // one lookup answer
    typedef struct {
        logic                      hit;
        logic [lfu_pkg::VAL_W-1:0] data;
    } cache_resp_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic             operation;
    logic [31:0]      key;
    logic [31:0]      value;
    logic             out_valid;
    logic             out_ready;
    logic             hit;
    logic [31:0]      data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [4:0]       cfg_data;

    lfu_cache_lru_tiebreak u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .key       (key),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .data      (data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the cache contents
    logic                      sh_valid [lfu_pkg::DEPTH];
    logic [lfu_pkg::KEY_W-1:0] sh_key   [lfu_pkg::DEPTH];
    logic [lfu_pkg::VAL_W-1:0] sh_value [lfu_pkg::DEPTH];
    logic [lfu_pkg::USE_W-1:0] sh_count [lfu_pkg::DEPTH];
    logic [lfu_pkg::IDX_W:0]   sh_rank  [lfu_pkg::DEPTH];
    int                        sh_occupancy;
    logic [lfu_pkg::CAP_W-1:0] sh_capacity;

    cache_req_t  pending_reqs[$];
    cache_resp_t expected_resps[$];

    int  error_count;
    int  sent_count;
    int  recv_count;
    int  hit_count;
    int  idle_cycles;
    int  send_gap;
    int  recv_gap;
    bit  traffic_on;
    int  cfg_writes;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // move entry idx to the front and bump its use count
    function automatic void shadow_bump(int idx);
        for (int i = 0; i < lfu_pkg::DEPTH; i++)
            if (sh_valid[i] && sh_rank[i] < sh_rank[idx])
                sh_rank[i]++;
        sh_rank[idx] = '0;
        if (sh_count[idx] != lfu_pkg::USE_MAX)
            sh_count[idx]++;
    endfunction

    // apply one request to the shadow cache and return the expected answer
    function automatic cache_resp_t lfu_lookup_update(cache_req_t rq);
        cache_resp_t rs;
        int cap;
        int idx;
        int slot;
        int r;
        cap  = (sh_capacity > lfu_pkg::DEPTH) ? lfu_pkg::DEPTH : int'(sh_capacity);
        idx  = -1;
        slot = -1;
        for (int i = lfu_pkg::DEPTH - 1; i >= 0; i--)
            if (sh_valid[i] && sh_key[i] == rq.k)
                idx = i;
        rs.hit  = (idx >= 0);
        rs.data = lfu_pkg::MISS_DATA;
        if (rq.op == lfu_pkg::OP_GET)
        begin
            if (idx >= 0)
            begin
                rs.data = sh_value[idx];
                shadow_bump(idx);
            end
        end
        else if (cap != 0)
        begin
            if (idx >= 0)
            begin
                sh_value[idx] = rq.v;
                shadow_bump(idx);
            end
            else
            begin
                // evict lowest count, oldest among equals
                if (sh_occupancy >= cap)
                begin
                    for (int i = 0; i < lfu_pkg::DEPTH; i++)
                        if (sh_valid[i] && (slot < 0 || sh_count[i] < sh_count[slot] ||
                            (sh_count[i] == sh_count[slot] && sh_rank[i] > sh_rank[slot])))
                            slot = i;
                    if (slot >= 0)
                    begin
                        r = sh_rank[slot];
                        sh_valid[slot] = 1'b0;
                        for (int i = 0; i < lfu_pkg::DEPTH; i++)
                            if (sh_valid[i] && sh_rank[i] > r)
                                sh_rank[i]--;
                        sh_occupancy--;
                    end
                end
                if (slot < 0)
                    for (int i = lfu_pkg::DEPTH - 1; i >= 0; i--)
                        if (!sh_valid[i])
                            slot = i;
                if (slot >= 0)
                begin
                    for (int i = 0; i < lfu_pkg::DEPTH; i++)
                        if (sh_valid[i])
                            sh_rank[i]++;
                    sh_valid[slot] = 1'b1;
                    sh_key[slot]   = rq.k;
                    sh_value[slot] = rq.v;
                    sh_count[slot] = lfu_pkg::USE_W'(1);
                    sh_rank[slot]  = '0;
                    sh_occupancy++;
                end
            end
        end
        return rs;
    endfunction

    function automatic cache_req_t make_req(logic op, logic [31:0] k, logic [31:0] v);
        cache_req_t rq;
        rq.op = op;
        rq.k  = k;
        rq.v  = v;
        return rq;
    endfunction

    function automatic int draw_gap();
        // about a third of requests see no idle at all
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            operation <= 1'b0;
            key       <= '0;
            value     <= '0;
            send_gap  <= 0;
        end
        else if (in_valid && !in_ready)
        begin
            // hold the request
        end
        else if (traffic_on && pending_reqs.size() > 0 && send_gap == 0)
        begin
            cache_req_t rq;
            rq = pending_reqs.pop_front();
            expected_resps.push_back(lfu_lookup_update(rq));
            in_valid   <= 1'b1;
            operation  <= rq.op;
            key        <= rq.k;
            value      <= rq.v;
            send_gap   <= draw_gap();
            sent_count <= sent_count + 1;
        end
        else
        begin
            in_valid <= 1'b0;
            if (send_gap > 0)
                send_gap <= send_gap - 1;
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                cache_resp_t ex;
                recv_count <= recv_count + 1;
                if (expected_resps.size() == 0)
                begin
                    $error("result with no request outstanding: hit=%0d data=%h", hit, data);
                    error_count++;
                end
                else
                begin
                    ex = expected_resps.pop_front();
                    if (hit !== ex.hit)
                    begin
                        $error("hit: expected %0d, actual %0d", ex.hit, hit);
                        error_count++;
                    end
                    if (data !== ex.data)
                    begin
                        $error("data: expected %h, actual %h", ex.data, data);
                        error_count++;
                    end
                    if (ex.hit)
                        hit_count <= hit_count + 1;
                end
                recv_gap  <= draw_gap();
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on stalled traffic
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || expected_resps.size() > 0 || in_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [lfu_pkg::CAP_W-1:0] cap);
        wait_idle();
        traffic_on = 1'b0;
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sh_capacity = cap;
        cfg_writes++;
        traffic_on = 1'b1;
    endtask

    // random phase: keys from a small pool so hits, updates and evictions occur
    task automatic random_phase(int n, int pool);
        logic [31:0] k;
        logic [31:0] v;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                k = $urandom();
            else
                k = 32'h5A00_0000 + $urandom_range(0, pool - 1);
            v = $urandom();
            pending_reqs.push_back(make_req(logic'($urandom_range(0, 1)), k, v));
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        traffic_on = 1'b0;
        error_count = 0;
        sent_count  = 0;
        recv_count  = 0;
        hit_count   = 0;
        cfg_writes  = 0;
        for (int i = 0; i < lfu_pkg::DEPTH; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_key[i]   = '0;
            sh_value[i] = '0;
            sh_count[i] = '0;
            sh_rank[i]  = '0;
        end
        sh_occupancy = 0;
        sh_capacity  = lfu_pkg::CAP_W'(lfu_pkg::CAP_RESET);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        traffic_on = 1'b1;

        // directed: extreme keys and values, hits, misses, overwrite
        pending_reqs.push_back(make_req(lfu_pkg::OP_GET, 32'h0000_0000, 32'h0));
        pending_reqs.push_back(make_req(lfu_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
        pending_reqs.push_back(make_req(lfu_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
        pending_reqs.push_back(make_req(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(lfu_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000));
        pending_reqs.push_back(make_req(lfu_pkg::OP_GET, 32'h8000_0000, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(lfu_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0));
        pending_reqs.push_back(make_req(lfu_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0));
        pending_reqs.push_back(make_req(lfu_pkg::OP_PUT, 32'h8000_0000, 32'h1234_5678));
        pending_reqs.push_back(make_req(lfu_pkg::OP_GET, 32'h8000_0000, 32'h0));
        pending_reqs.push_back(make_req(lfu_pkg::OP_GET, 32'h0000_0001, 32'h0));

        // capacity 1: occupancy is already above it, so every new key evicts an entry
        write_capacity(5'd1);
        pending_reqs.push_back(make_req(lfu_pkg::OP_PUT, 32'h0000_0010, 32'hAAAA_AAAA));
        pending_reqs.push_back(make_req(lfu_pkg::OP_PUT, 32'h0000_0011, 32'h5555_5555));
        pending_reqs.push_back(make_req(lfu_pkg::OP_GET, 32'h0000_0010, 32'h0));
        pending_reqs.push_back(make_req(lfu_pkg::OP_GET, 32'h0000_0011, 32'h0));

        // capacity zero: puts are dropped, gets still find old entries
        write_capacity(5'd0);
        pending_reqs.push_back(make_req(lfu_pkg::OP_PUT, 32'h0000_0020, 32'h1));
        pending_reqs.push_back(make_req(lfu_pkg::OP_PUT, 32'h0000_0011, 32'h2));
        pending_reqs.push_back(make_req(lfu_pkg::OP_GET, 32'h0000_0011, 32'h0));
        pending_reqs.push_back(make_req(lfu_pkg::OP_GET, 32'h0000_0020, 32'h0));
        random_phase(60, 8);

        // capacity above depth saturates at depth
        write_capacity(5'd31);
        random_phase(300, 24);
        // lowered below occupancy: evict-then-insert keeps occupancy
        write_capacity(5'd3);
        random_phase(250, 6);
        write_capacity(5'd16);
        random_phase(300, 20);
        write_capacity(5'd7);
        random_phase(200, 10);
        write_capacity(5'(($urandom_range(1, 17))));
        random_phase(200, 18);

        wait_idle();
        $display("Sent %0d requests, checked %0d results (%0d hits) over %0d capacity writes",
                 sent_count, recv_count, hit_count, cfg_writes);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
